// ----- hdl/dsl_tok_pkg.sv -----
// Shared types and constants for the DSL token scanner.
package dsl_tok_pkg;

  typedef enum logic [3:0] {
    TK_IDENT            = 4'd0,
    TK_STATE_SPACE      = 4'd1,
    TK_TRANSITION_ON    = 4'd2,
    TK_LBRACE           = 4'd3,
    TK_RBRACE           = 4'd4,
    TK_SEMICOLON        = 4'd5,
    TK_COLON            = 4'd6,
    TK_PIPE             = 4'd7,
    TK_EOF              = 4'd8,
    TK_ERROR            = 4'd9
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] line;
  } token_t;

  // Tokens caused by one byte: one or two.
  typedef struct packed {
    token_t first;
    token_t second;
    logic   two;
  } tok_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = 2;

  localparam int KW_SS_LEN = 10;
  localparam int KW_TO_LEN = 12;

  localparam logic [7:0] KW_SS [KW_SS_LEN] = '{
    8'h53, 8'h74, 8'h61, 8'h74, 8'h65, 8'h53, 8'h70, 8'h61, 8'h63, 8'h65
  };
  localparam logic [7:0] KW_TO [KW_TO_LEN] = '{
    8'h54, 8'h72, 8'h61, 8'h6E, 8'h73, 8'h69, 8'h74, 8'h69, 8'h6F, 8'h6E,
    8'h4F, 8'h6E
  };

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LBR   = 8'h7B;
  localparam logic [7:0] CH_RBR   = 8'h7D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_UNDER = 8'h5F;

endpackage

// ----- hdl/dsl_tok_ifs.sv -----
// Valid/ready channel interfaces for source bytes and tokens.
interface dsl_tok_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  modport source (output valid, output source_byte, input ready);
  modport sink (input valid, input source_byte, output ready);
endinterface

interface dsl_tok_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [15:0] token_line;
  logic        last_of_run;
  modport source (output valid, output token_kind, output token_start, output token_length,
                  output token_line, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_start, input token_length,
                input token_line, input last_of_run, output ready);
endinterface

// ----- hdl/dsl_tok_scanner_top.sv -----
// Top level of the DSL token scanner: front end, record queue, back end.
//
//   channel  dir  payload                                                 
//   source   in   source_byte[7:0]
//   tokens   out  token_kind[3:0] token_start token_length token_line last_of_run
//
// One source byte is taken per cycle while the four-entry record queue has room.
// Tokens leave at one per cycle while tokens.ready is high; a byte that closes an identifier
// and also gives a token of its own yields two tokens, which the queue absorbs.
// A byte's first token is registered in a queue entry and then in the output register.
// rst is synchronous: offset 0, line 1, no identifier open, queue and output empty.
// A stall on tokens fills the queue and then drops source.ready.
module dsl_token_scanner_top #(
  parameter int OFFSET_BITS = 16,
  parameter int LINE_BITS   = 16
) (
  input  logic            clk,
  input  logic            rst,
  dsl_tok_byte_if.sink    source,
  dsl_tok_token_if.source tokens
);
  import dsl_tok_pkg::*;

  logic     push, pop;
  tok_rec_t wr_rec, rd_rec;
  q_stat_t  q_stat;

  dsl_tok_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .source (source),
    .q_stat (q_stat),
    .push   (push),
    .rec    (wr_rec)
  );

  dsl_tok_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_rec (wr_rec),
    .pop    (pop),
    .rd_rec (rd_rec),
    .stat   (q_stat)
  );

  dsl_tok_back u_back (
    .clk    (clk),
    .rst    (rst),
    .rd_rec (rd_rec),
    .q_stat (q_stat),
    .pop    (pop),
    .tokens (tokens)
  );

endmodule

// ----- hdl/dsl_tok_front.sv -----
// Front end: scanner state, byte classification and token record build.
module dsl_tok_front #(
  parameter int OFFSET_BITS = 16,
  parameter int LINE_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  dsl_tok_byte_if.sink         source,
  input  dsl_tok_pkg::q_stat_t q_stat,
  output logic                 push,
  output dsl_tok_pkg::tok_rec_t rec
);
  import dsl_tok_pkg::*;

  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic [LINE_BITS-1:0]   line_count, line_count_next;
  logic                   ident_open, ident_open_next;
  logic [OFFSET_BITS-1:0] ident_start, ident_start_next;
  logic [OFFSET_BITS-1:0] ident_length, ident_length_next;
  logic                   match_ss, match_ss_next;
  logic                   match_to, match_to_next;

  logic [7:0] c;
  logic       lead_ch, num_ch, take;
  logic       close_ident, emit_byte;
  tok_kind_t  byte_kind, ident_kind;
  token_t     ident_tok, byte_tok;
  logic [15:0] off16, line16;

  function automatic logic [15:0] sat16(input logic [31:0] v);
    sat16 = (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
  endfunction

  assign c        = source.source_byte;
  assign lead_ch  = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                    (c == CH_UNDER);
  assign num_ch   = (c >= 8'h30 && c <= 8'h39);
  assign take     = source.valid && source.ready;
  assign source.ready = !q_stat.full;

  assign off16  = sat16(32'(byte_offset));
  assign line16 = sat16(32'(line_count));

  always_comb begin
    if (match_ss && ident_length == OFFSET_BITS'(KW_SS_LEN)) begin
      ident_kind = TK_STATE_SPACE;
    end else if (match_to && ident_length == OFFSET_BITS'(KW_TO_LEN)) begin
      ident_kind = TK_TRANSITION_ON;
    end else begin
      ident_kind = TK_IDENT;
    end
  end

  always_comb begin
    emit_byte = 1'b1;
    byte_kind = TK_ERROR;
    case (c)
      CH_NUL:   byte_kind = TK_EOF;
      CH_SPACE: emit_byte = 1'b0;
      CH_TAB:   emit_byte = 1'b0;
      CH_CR:    emit_byte = 1'b0;
      CH_LF:    emit_byte = 1'b0;
      CH_LBR:   byte_kind = TK_LBRACE;
      CH_RBR:   byte_kind = TK_RBRACE;
      CH_SEMI:  byte_kind = TK_SEMICOLON;
      CH_COLON: byte_kind = TK_COLON;
      CH_PIPE:  byte_kind = TK_PIPE;
      default:  emit_byte = !lead_ch;
    endcase
    if (ident_open && (lead_ch || num_ch)) begin
      emit_byte = 1'b0;
    end
  end

  assign close_ident = ident_open && !(lead_ch || num_ch);

  always_comb begin
    ident_tok.kind   = ident_kind;
    ident_tok.start  = sat16(32'(ident_start));
    ident_tok.length = sat16(32'(ident_length));
    ident_tok.line   = line16;
    byte_tok.kind    = byte_kind;
    byte_tok.start   = off16;
    byte_tok.length  = (c == CH_NUL) ? 16'd0 : 16'd1;
    byte_tok.line    = line16;
  end

  always_comb begin
    rec.first  = close_ident ? ident_tok : byte_tok;
    rec.second = byte_tok;
    rec.two    = close_ident && emit_byte;
    push       = take && (close_ident || emit_byte);
  end

  always_comb begin
    byte_offset_next  = byte_offset;
    line_count_next   = line_count;
    ident_open_next   = ident_open;
    ident_start_next  = ident_start;
    ident_length_next = ident_length;
    match_ss_next     = match_ss;
    match_to_next     = match_to;
    if (!(&byte_offset)) begin
      byte_offset_next = byte_offset + OFFSET_BITS'(1);
    end
    if (ident_open && (lead_ch || num_ch)) begin
      match_ss_next = match_ss && (ident_length < OFFSET_BITS'(KW_SS_LEN)) &&
                      (c == KW_SS[ident_length[3:0]]);
      match_to_next = match_to && (ident_length < OFFSET_BITS'(KW_TO_LEN)) &&
                      (c == KW_TO[ident_length[3:0]]);
      if (!(&ident_length)) begin
        ident_length_next = ident_length + OFFSET_BITS'(1);
      end
    end else begin
      ident_open_next   = 1'b0;
      ident_length_next = '0;
      match_ss_next     = 1'b0;
      match_to_next     = 1'b0;
      if (c == CH_NUL) begin
        byte_offset_next = '0;
        line_count_next  = LINE_BITS'(1);
      end else if (c == CH_LF) begin
        if (!(&line_count)) begin
          line_count_next = line_count + LINE_BITS'(1);
        end
      end else if (lead_ch) begin
        ident_open_next   = 1'b1;
        ident_start_next  = byte_offset;
        ident_length_next = OFFSET_BITS'(1);
        match_ss_next     = (c == KW_SS[0]);
        match_to_next     = (c == KW_TO[0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset  <= '0;
      line_count   <= LINE_BITS'(1);
      ident_open   <= 1'b0;
      ident_start  <= '0;
      ident_length <= '0;
      match_ss     <= 1'b0;
      match_to     <= 1'b0;
    end else if (take) begin
      byte_offset  <= byte_offset_next;
      line_count   <= line_count_next;
      ident_open   <= ident_open_next;
      ident_start  <= ident_start_next;
      ident_length <= ident_length_next;
      match_ss     <= match_ss_next;
      match_to     <= match_to_next;
    end
  end

endmodule

// ----- hdl/dsl_tok_queue.sv -----
// Short queue of token records between front and back ends.
module dsl_tok_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  dsl_tok_pkg::tok_rec_t wr_rec,
  input  logic                  pop,
  output dsl_tok_pkg::tok_rec_t rd_rec,
  output dsl_tok_pkg::q_stat_t  stat
);
  import dsl_tok_pkg::*;

  tok_rec_t             entries [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign stat.full  = (count == (QPTR_BITS+1)'(QDEPTH));
  assign stat.empty = (count == '0);
  assign rd_rec     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_BITS+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_BITS+1)'(1);
      end
    end
  end

endmodule

// ----- hdl/dsl_tok_back.sv -----
// Back end: splits token records into single tokens behind an output register.
module dsl_tok_back (
  input  logic                  clk,
  input  logic                  rst,
  input  dsl_tok_pkg::tok_rec_t rd_rec,
  input  dsl_tok_pkg::q_stat_t  q_stat,
  output logic                  pop,
  dsl_tok_token_if.source       tokens
);
  import dsl_tok_pkg::*;

  logic   out_valid;
  token_t out_tok;
  logic   out_last;
  logic   pend;
  token_t pend_tok;
  logic   load;

  assign load = !out_valid || tokens.ready;
  assign pop  = load && !pend && !q_stat.empty;

  assign tokens.valid        = out_valid;
  assign tokens.token_kind   = out_tok.kind;
  assign tokens.token_start  = out_tok.start;
  assign tokens.token_length = out_tok.length;
  assign tokens.token_line   = out_tok.line;
  assign tokens.last_of_run  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (load) begin
      if (pend) begin
        out_valid <= 1'b1;
        pend      <= 1'b0;
      end else begin
        out_valid <= !q_stat.empty;
        pend      <= !q_stat.empty && rd_rec.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend) begin
        out_tok  <= pend_tok;
        out_last <= 1'b1;
      end else begin
        out_tok  <= rd_rec.first;
        out_last <= !rd_rec.two;
        pend_tok <= rd_rec.second;
      end
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for dsl_token_scanner_top: byte stimulus, token prediction, checks.
package tb_scan_pkg;
  import dsl_tok_pkg::*;

  typedef struct {
    token_t tok;
    logic   last;
  } due_token_t;

  class token_ledger;
    logic [15:0] offset = 16'd0;
    logic [15:0] line_no = 16'd1;
    bit          id_open = 1'b0;
    logic [15:0] id_start = 16'd0;
    logic [15:0] id_len = 16'd0;
    bit          ss_ok = 1'b0;
    bit          to_ok = 1'b0;
    due_token_t  due_tokens[$];
    int          errors = 0;

    function bit is_lead(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
    endfunction

    function bit is_word(logic [7:0] c);
      return is_lead(c) || (c >= "0" && c <= "9");
    endfunction

    function void push_token(tok_kind_t k, logic [15:0] start, logic [15:0] length);
      due_token_t d;
      d.tok = '{kind: k, start: start, length: length, line: line_no};
      d.last = 1'b0;
      due_tokens.push_back(d);
    endfunction

    // Tokens caused by one accepted byte.
    function void take_byte(logic [7:0] c);
      tok_kind_t k;
      bit        emit;
      int        n_before;
      n_before = due_tokens.size();
      if (id_open) begin
        if (is_word(c)) begin
          if (id_len < KW_SS_LEN) ss_ok = ss_ok && (c == KW_SS[id_len]);
          else ss_ok = 1'b0;
          if (id_len < KW_TO_LEN) to_ok = to_ok && (c == KW_TO[id_len]);
          else to_ok = 1'b0;
          if (id_len != 16'hFFFF) id_len++;
          if (offset != 16'hFFFF) offset++;
          return;
        end
        k = TK_IDENT;
        if (ss_ok && id_len == KW_SS_LEN) k = TK_STATE_SPACE;
        else if (to_ok && id_len == KW_TO_LEN) k = TK_TRANSITION_ON;
        push_token(k, id_start, id_len);
        id_open = 1'b0;
        id_len = 16'd0;
        ss_ok = 1'b0;
        to_ok = 1'b0;
      end
      if (c == CH_NUL) begin
        push_token(TK_EOF, offset, 16'd0);
        offset = 16'd0;
        line_no = 16'd1;
      end else begin
        emit = 1'b1;
        k = TK_ERROR;
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
          emit = 1'b0;
        end else if (c == CH_LF) begin
          emit = 1'b0;
          if (line_no != 16'hFFFF) line_no++;
        end else if (is_lead(c)) begin
          emit = 1'b0;
          id_open = 1'b1;
          id_start = offset;
          id_len = 16'd1;
          ss_ok = (c == KW_SS[0]);
          to_ok = (c == KW_TO[0]);
        end else if (c == CH_LBR) begin
          k = TK_LBRACE;
        end else if (c == CH_RBR) begin
          k = TK_RBRACE;
        end else if (c == CH_SEMI) begin
          k = TK_SEMICOLON;
        end else if (c == CH_COLON) begin
          k = TK_COLON;
        end else if (c == CH_PIPE) begin
          k = TK_PIPE;
        end
        if (emit) push_token(k, offset, 16'd1);
        if (offset != 16'hFFFF) offset++;
      end
      if (due_tokens.size() > n_before) due_tokens[due_tokens.size() - 1].last = 1'b1;
    endfunction

    function void field_ok(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void match_token(logic [3:0] kind, logic [15:0] start, logic [15:0] length,
                              logic [15:0] line, logic last);
      due_token_t d;
      if (due_tokens.size() == 0) begin
        $display("%0t: unexpected token, expected none, actual kind %0d start %0d",
                 $time, kind, start);
        errors++;
        return;
      end
      d = due_tokens.pop_front();
      field_ok("token_kind", 16'(d.tok.kind), 16'(kind));
      field_ok("token_start", d.tok.start, start);
      field_ok("token_length", d.tok.length, length);
      field_ok("token_line", d.tok.line, line);
      field_ok("last_of_run", 16'(d.last), 16'(last));
    endfunction
  endclass
endpackage

module tb_top;
  import dsl_tok_pkg::*;
  import tb_scan_pkg::*;

  localparam int          RANDOM_BYTES = 1250;
  localparam int          DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 4000000;

  localparam logic [7:0] PUNCT [5] = '{CH_LBR, CH_RBR, CH_SEMI, CH_COLON, CH_PIPE};
  localparam logic [7:0] BLANK [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

  localparam string WORD_CHARS =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  localparam int    LEAD_CHARS = 53;
  localparam string BAD_CHARS = "!\"#$%&'()*+,-./0123456789<=>?@[\\]^`~";

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned cycle_count = 0;
  int          burst_left = 0;
  int          bytes_sent = 0;
  int          stall_left = 0;
  int          mode_left = 0;
  int          stall_mode = 0;

  token_ledger ledger = new;

  dsl_tok_byte_if  src_if ();
  dsl_tok_token_if tok_if ();

  dsl_token_scanner_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .source (src_if),
    .tokens (tok_if)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (src_if.valid === 1'b1 && src_if.ready === 1'b1) ledger.take_byte(src_if.source_byte);
      if (tok_if.valid === 1'b1 && tok_if.ready === 1'b1) begin
        ledger.match_token(tok_if.token_kind, tok_if.token_start, tok_if.token_length,
                           tok_if.token_line, tok_if.last_of_run);
      end
    end
  end

  // Token sink: stall behaviour switches at random among four modes.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(50, 400);
    end else begin
      mode_left--;
    end
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      case (stall_mode)
        1: if ($urandom_range(0, 3) == 0) stall_left = 1;
        2: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(2, 12);
        3: if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 3);
        default: ;
      endcase
    end
    tok_if.ready <= !rst && (stall_left == 0);
  end

  task automatic send_byte(input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        src_if.valid <= 1'b0;
        src_if.source_byte <= 8'($urandom);
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    src_if.valid <= 1'b1;
    src_if.source_byte <= c;
    do @(posedge clk); while (src_if.ready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic string random_ident();
    string s;
    int    n;
    s = $sformatf("%c", WORD_CHARS[$urandom_range(0, LEAD_CHARS - 1)]);
    n = $urandom_range(0, 15);
    for (int i = 0; i < n; i++)
      s = $sformatf("%s%c", s, WORD_CHARS[$urandom_range(0, WORD_CHARS.len() - 1)]);
    return s;
  endfunction

  // Keyword with one defect: cut short, one byte too many, or one byte changed.
  function automatic string near_keyword();
    string s;
    int    i;
    s = ($urandom_range(0, 1) != 0) ? "StateSpace" : "TransitionOn";
    i = $urandom_range(1, s.len() - 1);
    case ($urandom_range(0, 2))
      0: s = s.substr(0, i - 1);
      1: s = $sformatf("%s%c", s, WORD_CHARS[$urandom_range(0, WORD_CHARS.len() - 1)]);
      default: s.putc(i, WORD_CHARS[$urandom_range(0, WORD_CHARS.len() - 1)]);
    endcase
    return s;
  endfunction

  function automatic logic [7:0] bad_byte();
    case ($urandom_range(0, 2))
      0: return 8'($urandom_range(127, 255));
      1: return 8'($urandom_range(1, 8));
      default: return BAD_CHARS[$urandom_range(0, BAD_CHARS.len() - 1)];
    endcase
  endfunction

  task automatic random_phrase();
    int pick;
    bit wordy;
    pick = $urandom_range(0, 99);
    wordy = 1'b0;
    if (pick < 10) begin
      send_text("StateSpace");
      wordy = 1'b1;
    end else if (pick < 20) begin
      send_text("TransitionOn");
      wordy = 1'b1;
    end else if (pick < 32) begin
      send_text(near_keyword());
      wordy = 1'b1;
    end else if (pick < 50) begin
      send_text(random_ident());
      wordy = 1'b1;
    end else if (pick < 66) begin
      send_byte(PUNCT[$urandom_range(0, 4)]);
    end else if (pick < 82) begin
      send_byte(BLANK[$urandom_range(0, 3)]);
    end else if (pick < 84) begin
      send_byte(CH_NUL);
    end else if (pick < 92) begin
      send_byte(bad_byte());
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
    if (wordy && $urandom_range(0, 3) != 0) begin
      if ($urandom_range(0, 1) != 0) send_byte(PUNCT[$urandom_range(0, 4)]);
      else send_byte(BLANK[$urandom_range(0, 3)]);
    end
  endtask

  initial begin
    int target;
    src_if.valid = 1'b0;
    src_if.source_byte = 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_text("StateSpace{TransitionOn:_x9|;}\t\r\nq\n");
    send_byte(8'h80);
    send_byte(8'hFF);
    send_text("@z");
    send_byte(CH_NUL);
    send_byte(CH_NUL);

    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) random_phrase();
    send_byte(CH_NUL);

    send_text("TransitionOn;");

    src_if.valid <= 1'b0;
    while (ledger.due_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
